// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the random value core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(LBL, CLK, RSTN, ANTE, CONS) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error("next-cycle implication failed");

`endif

// ===== src/bur_pkg.sv =====
// Package of the bounded uniform random core: widths, codes, state types
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package bur_pkg;

	localparam int unsigned HALF_W  = 16;
	localparam int unsigned FULL_W  = 2 * HALF_W;
	localparam int unsigned RANGE_W = HALF_W + 1;
	localparam int unsigned CNT_W   = $clog2(HALF_W + 1);

	localparam logic [HALF_W-1:0] HALF_MASK = '1;
	localparam logic [FULL_W-1:0] FULL_MASK = '1;

	// Request type codes.
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_SUPPLY = 1'b1;

	// Progress of the request being served.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FULL_HI,
		PH_PASS,
		PH_DRAW
	} phase_t;

	// Controller sequencing states.
	typedef enum logic [1:0] {
		CS_ACCEPT,
		CS_EXEC,
		CS_MOD
	} ctl_state_t;

	typedef struct packed {
		logic load_item;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic emit;
		logic need_mod;
		logic mod_done;
		logic out_blocked;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== src/bur_mod.sv =====
// Iterative remainder unit: computes 2^HALF_W mod divisor, one bit per cycle.
// Depends on bur_pkg.
`default_nettype none

module bur_mod
	import bur_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [RANGE_W-1:0] divisor,
	output logic                    done,
	output logic [HALF_W-1:0]       rem
);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RANGE_W-1:0] rem_q;
	logic [RANGE_W-1:0] div_q;
	logic [RANGE_W:0]   shifted;
	logic [RANGE_W:0]   rem_nxt;

	// The dividend is a single one bit, so the remainder starts at one and
	// each step shifts in a zero and subtracts the divisor when it fits.
	always_comb begin
		shifted = {rem_q, 1'b0};
		if (shifted >= {1'b0, div_q}) begin
			rem_nxt = shifted - {1'b0, div_q};
		end else begin
			rem_nxt = shifted;
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign rem  = rem_q[HALF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(HALF_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RANGE_W'(1);
			div_q <= divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= rem_nxt[RANGE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== src/bur_ctrl.sv =====
// Controller of the bounded uniform random core: sequences beat capture,
// execution and threshold computation. Depends on bur_pkg.
`default_nettype none

module bur_ctrl
	import bur_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_ACCEPT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		in_ready      = 1'b0;
		cmd.load_item = 1'b0;
		cmd.exec      = 1'b0;
		case (state_q)
			CS_ACCEPT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = CS_EXEC;
				end
			end
			CS_EXEC: begin
				// Hold the beat while its result cannot enter the output register.
				if (!(sts.emit && sts.out_blocked)) begin
					cmd.exec  = 1'b1;
					state_nxt = sts.need_mod ? CS_MOD : CS_ACCEPT;
				end
			end
			CS_MOD: begin
				if (sts.mod_done) begin
					state_nxt = CS_ACCEPT;
				end
			end
			default: begin
				state_nxt = CS_ACCEPT;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/bur_datapath.sv =====
// Datapath of the bounded uniform random core: beat registers, request state,
// multiply-high with rejection and the output register. Depends on bur_pkg, bur_mod.
`default_nettype none

module bur_datapath
	import bur_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	input  wire logic              req_type,
	input  wire logic [FULL_W-1:0] bound,
	input  wire logic [HALF_W-1:0] entropy_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [FULL_W-1:0]      value
);

	// Captured beat.
	logic              kind_q;
	logic [FULL_W-1:0] bound_q;
	logic [HALF_W-1:0] word_q;

	// Request state.
	phase_t             phase_q;
	logic [RANGE_W-1:0] range_q;
	logic [HALF_W-1:0]  thr_q;
	logic [HALF_W-1:0]  bup_q;
	logic [HALF_W-1:0]  blo_q;
	logic [HALF_W-1:0]  upick_q;
	logic               split_q;

	logic              out_valid_q;
	logic [FULL_W-1:0] value_q;

	// Next values.
	phase_t             phase_nxt;
	logic [RANGE_W-1:0] range_nxt;
	logic [HALF_W-1:0]  bup_nxt;
	logic [HALF_W-1:0]  blo_nxt;
	logic [HALF_W-1:0]  upick_nxt;
	logic               split_nxt;
	logic               emit_c;
	logic               need_mod_c;
	logic [FULL_W-1:0]  emit_val;
	logic               half_go;
	logic [HALF_W-1:0]  half_b;

	logic [HALF_W+RANGE_W-1:0] prod;
	logic [HALF_W-1:0]         prod_lo;
	logic [HALF_W-1:0]         pick;
	logic                      reject;

	logic              mod_done;
	logic [HALF_W-1:0] mod_rem;

	assign prod    = {{RANGE_W{1'b0}}, word_q} * {{HALF_W{1'b0}}, range_q};
	assign prod_lo = prod[HALF_W-1:0];
	assign pick    = prod[FULL_W-1:HALF_W];
	assign reject  = prod_lo < thr_q;

	always_comb begin
		phase_nxt  = phase_q;
		range_nxt  = range_q;
		bup_nxt    = bup_q;
		blo_nxt    = blo_q;
		upick_nxt  = upick_q;
		split_nxt  = split_q;
		emit_c     = 1'b0;
		need_mod_c = 1'b0;
		emit_val   = {upick_q, word_q};
		half_go    = 1'b0;
		half_b     = bound_q[HALF_W-1:0];

		if (kind_q == REQ_START) begin
			upick_nxt = '0;
			split_nxt = 1'b0;
			if (bound_q == FULL_MASK) begin
				phase_nxt = PH_FULL_HI;
			end else if (bound_q[FULL_W-1:HALF_W] == '0) begin
				half_go = 1'b1;
				half_b  = bound_q[HALF_W-1:0];
			end else begin
				bup_nxt    = bound_q[FULL_W-1:HALF_W];
				blo_nxt    = bound_q[HALF_W-1:0];
				range_nxt  = {1'b0, bound_q[FULL_W-1:HALF_W]} + RANGE_W'(1);
				need_mod_c = 1'b1;
				split_nxt  = 1'b1;
				phase_nxt  = PH_DRAW;
			end
		end else begin
			case (phase_q)
				PH_FULL_HI: begin
					upick_nxt = word_q;
					phase_nxt = PH_PASS;
				end
				PH_PASS: begin
					emit_c    = 1'b1;
					emit_val  = {upick_q, word_q};
					phase_nxt = PH_IDLE;
				end
				PH_DRAW: begin
					if (!reject) begin
						if (!split_q) begin
							emit_c    = 1'b1;
							emit_val  = {upick_q, pick};
							phase_nxt = PH_IDLE;
						end else begin
							upick_nxt = pick;
							split_nxt = 1'b0;
							if (pick < bup_q) begin
								phase_nxt = PH_PASS;
							end else begin
								half_go = 1'b1;
								half_b  = blo_q;
							end
						end
					end
				end
				default: begin
					phase_nxt = PH_IDLE;
				end
			endcase
		end

		// Draw within a single half, using the upper half already chosen.
		if (half_go) begin
			if (half_b == '0) begin
				emit_c    = 1'b1;
				emit_val  = {upick_nxt, {HALF_W{1'b0}}};
				phase_nxt = PH_IDLE;
			end else if (half_b == HALF_MASK) begin
				phase_nxt = PH_PASS;
			end else begin
				range_nxt  = {1'b0, half_b} + RANGE_W'(1);
				need_mod_c = 1'b1;
				phase_nxt  = PH_DRAW;
			end
		end
	end

	bur_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.exec && need_mod_c),
		.divisor (range_nxt),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= req_type;
			bound_q <= bound;
			word_q  <= entropy_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			range_q <= '0;
			thr_q   <= '0;
			bup_q   <= '0;
			blo_q   <= '0;
			upick_q <= '0;
			split_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				phase_q <= phase_nxt;
				range_q <= range_nxt;
				bup_q   <= bup_nxt;
				blo_q   <= blo_nxt;
				upick_q <= upick_nxt;
				split_q <= split_nxt;
			end
			if (mod_done) begin
				thr_q <= mod_rem;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec && emit_c) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && emit_c) begin
			value_q <= emit_val;
		end
	end

	assign out_valid       = out_valid_q;
	assign value           = value_q;
	assign sts.emit        = emit_c;
	assign sts.need_mod    = need_mod_c;
	assign sts.mod_done    = mod_done;
	assign sts.out_blocked = out_valid_q && !out_ready;

endmodule

`default_nettype wire

// ===== src/bounded_uniform_random_core.sv =====
// Bounded uniform random core: an accepted beat is captured, then executed; a result
// is registered to out_valid. The next beat is taken only after execute; a beat that
// loads a new range first waits for the shift-subtract remainder unit that builds the
// rejection threshold (16 iterations plus a completion step).
// Reset (arst_n, asynchronous, active low) returns to no request in progress,
// with all request state zero and no result pending.
`default_nettype none

module bounded_uniform_random_core
	import bur_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              req_type,
	input  wire logic [FULL_W-1:0] bound,
	input  wire logic [HALF_W-1:0] entropy_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [FULL_W-1:0]      value
);

	// The controller sequences each beat through a capture step and an
	// execute step. During execute the datapath multiplies the entropy word
	// by the range size, tests the low half against the rejection threshold
	// and updates the request state. A result goes to a one-entry output
	// register; an execute that would overwrite an untaken result waits,
	// while beats that produce no result proceed regardless.
	dp_cmd_t cmd;
	dp_sts_t sts;

	bur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Whenever a new range is loaded (a start beat, or the lower half of a
	// split bound), the threshold 2^16 mod range is computed iteratively
	// before the next beat is taken.
	bur_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.bound        (bound),
		.entropy_word (entropy_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value        (value)
	);

endmodule

`default_nettype wire

// ===== src/bur_checker.sv =====
// Port-level checker of the bounded uniform random core and its bind.
// Depends on bur_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bur_checker
	import bur_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              req_type,
	input wire logic [FULL_W-1:0] bound,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [FULL_W-1:0] value
);

	logic [FULL_W-1:0] bound_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_seen_q <= '0;
		end else if (in_valid && in_ready && (req_type == REQ_START)) begin
			bound_seen_q <= bound;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(value))
	`ASSERT_NEXT(a_exec_gap, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_IMPL(a_in_range, clk, arst_n, $rose(out_valid), value <= bound_seen_q)

endmodule

bind bounded_uniform_random_core bur_checker u_bur_checker (.*);

`default_nettype wire
